// File: rtl/mpd_pkg.sv
// ============================================================================
// mpd_pkg
// Shared sizes, state type and controller/datapath interface structs for the
// minimum partition difference block.
// ============================================================================
package mpd_pkg;

   // Largest number of weights kept for one search.
   localparam int MAX_ITEMS   = 16;
   // Width of one weight.
   localparam int WEIGHT_BITS = 32;
   // Width of the total, subset sum and difference.
   localparam int SUM_BITS    = 36;
   // Item counter holds 0 to MAX_ITEMS.
   localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);
   // Index of one stored weight.
   localparam int IDX_BITS    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   // Subset step counter holds 0 to 2^MAX_ITEMS.
   localparam int STEP_BITS   = MAX_ITEMS + 1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEARCH,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // store one accepted weight
      logic start;   // begin a search with the empty subset
      logic step;    // advance one Gray-code subset
      logic clear;   // result taken, empty the set
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic step_done;  // every subset has been visited
      logic pipe_busy;  // weight reads or differences still in flight
   } status_type;

endpackage

// File: rtl/mpd_ctrl.sv
// ============================================================================
// mpd_ctrl
// Controller state machine: loads weights, sequences the subset search,
// drains the difference pipeline and presents the result.
// ============================================================================
module mpd_ctrl
   import mpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_weight,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last_weight) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.step_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall  = 1'b0;
            cmd.load   = req_valid;
            cmd.start  = req_valid & req_last_weight;
         end
         ST_SEARCH: begin
            cmd.step = ~status.step_done;
         end
         ST_DRAIN: begin
            req_stall = 1'b1;
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            cmd.clear = ~rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/mpd_datapath.sv
// ============================================================================
// mpd_datapath
// Weight store with a registered read, running total, Gray-code subset sum
// and a two-stage difference/minimum pipeline.
// ============================================================================
module mpd_datapath
   import mpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [WEIGHT_BITS-1:0] req_weight,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [SUM_BITS-1:0]    best_difference
);

   // Position of the lowest set bit of a step count.
   function automatic logic [IDX_BITS-1:0] lowest_bit(input logic [STEP_BITS-1:0] value);
      logic [IDX_BITS-1:0] pos;
      pos = '0;
      for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
         if (value[i]) begin
            pos = IDX_BITS'(i);
         end
      end
      return pos;
   endfunction

   logic [WEIGHT_BITS-1:0] weight_store [MAX_ITEMS];
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic [SUM_BITS-1:0]    total_ff;
   logic [SUM_BITS-1:0]    total_in;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;
   logic [MAX_ITEMS-1:0]   code_ff;
   logic [MAX_ITEMS-1:0]   code_in;
   logic [STEP_BITS-1:0]   step_ff;
   logic [STEP_BITS-1:0]   step_in;
   logic [WEIGHT_BITS-1:0] rd_weight_ff;
   logic [IDX_BITS-1:0]    rd_bit_ff;
   logic                   rd_vld_ff;
   logic                   rd_vld_in;
   logic                   sum_vld_ff;
   logic                   sum_vld_in;
   logic [SUM_BITS-1:0]    diff_ff;
   logic [SUM_BITS-1:0]    diff_in;
   logic                   diff_vld_ff;
   logic                   diff_vld_in;
   logic [SUM_BITS-1:0]    best_ff;
   logic [SUM_BITS-1:0]    best_in;
   logic                   store_ok;
   logic [IDX_BITS-1:0]    step_bit;
   logic [STEP_BITS-1:0]   step_limit;
   logic [SUM_BITS:0]      twice_sum;
   logic [SUM_BITS:0]      total_ext;

   // A weight is stored only while there is room.
   assign store_ok = (count_ff < COUNT_BITS'(MAX_ITEMS));

   // Weight store write.
   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         weight_store[count_ff[IDX_BITS-1:0]] <= req_weight;
      end
   end

   // Gray-code step: the flipped bit is the lowest set bit of the step count.
   assign step_bit    = lowest_bit(step_ff);
   assign step_limit  = STEP_BITS'(1) << count_ff;

   // Weight store read: the weight and bit of a step are applied in the cycle
   // after the step is issued.
   always_ff @(posedge clock) begin
      rd_weight_ff <= weight_store[step_bit];
      rd_bit_ff    <= step_bit;
   end

   // Count, total, subset sum and step count.
   always_comb begin
      count_in   = count_ff;
      total_in   = total_ff;
      sum_in     = sum_ff;
      code_in    = code_ff;
      step_in    = step_ff;
      rd_vld_in  = 1'b0;
      sum_vld_in = 1'b0;
      if (cmd.clear) begin
         count_in = '0;
         total_in = '0;
      end else if (cmd.load && store_ok) begin
         count_in = count_ff + COUNT_BITS'(1);
         total_in = total_ff + SUM_BITS'(req_weight);
      end
      if (cmd.start) begin
         sum_in     = '0;
         code_in    = '0;
         step_in    = STEP_BITS'(1);
         sum_vld_in = 1'b1;
      end else begin
         if (cmd.step) begin
            step_in   = step_ff + STEP_BITS'(1);
            rd_vld_in = 1'b1;
         end
         if (rd_vld_ff) begin
            code_in[rd_bit_ff] = ~code_ff[rd_bit_ff];
            if (code_ff[rd_bit_ff]) begin
               sum_in = sum_ff - SUM_BITS'(rd_weight_ff);
            end else begin
               sum_in = sum_ff + SUM_BITS'(rd_weight_ff);
            end
            sum_vld_in = 1'b1;
         end
      end
   end

   // Difference |total - 2 * subset sum| of the registered subset.
   assign twice_sum = {sum_ff, 1'b0};
   assign total_ext = {1'b0, total_ff};
   always_comb begin
      if (twice_sum >= total_ext) begin
         diff_in = SUM_BITS'(twice_sum - total_ext);
      end else begin
         diff_in = SUM_BITS'(total_ext - twice_sum);
      end
      diff_vld_in = sum_vld_ff;
   end

   // Running minimum.
   always_comb begin
      best_in = best_ff;
      if (cmd.clear || cmd.start) begin
         best_in = '1;
      end else if (diff_vld_ff && (diff_ff < best_ff)) begin
         best_in = diff_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         total_ff    <= '0;
         sum_ff      <= '0;
         code_ff     <= '0;
         step_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         sum_vld_ff  <= 1'b0;
         diff_vld_ff <= 1'b0;
         best_ff     <= '1;
      end else begin
         count_ff    <= count_in;
         total_ff    <= total_in;
         sum_ff      <= sum_in;
         code_ff     <= code_in;
         step_ff     <= step_in;
         rd_vld_ff   <= rd_vld_in;
         sum_vld_ff  <= sum_vld_in;
         diff_vld_ff <= diff_vld_in;
         best_ff     <= best_in;
      end
   end

   // Difference payload register.
   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   // Status back to the controller.
   assign status.step_done = (step_ff == step_limit);
   assign status.pipe_busy = rd_vld_ff | sum_vld_ff | diff_vld_ff;
   assign best_difference  = best_ff;

endmodule

// File: rtl/min_partition_difference.sv
// ============================================================================
// min_partition_difference
// Collects weights and, after the last one, searches every subset for the
// smallest difference between the two groups of a split.
// ============================================================================
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_stall    req_weight, req_last_weight
//   rsp_      out         rsp_valid/rsp_stall    rsp_min_difference
//
// Weights are taken one per cycle. After the last weight the block stalls
// requests (N weights stored, at most 16) while one Gray-code step per
// cycle reads a stored weight and, in the next cycle, updates the subset
// sum, followed by a two-stage difference and minimum pipeline.
// The result is then held until taken, with requests stalled meanwhile.
// Weights beyond 16 are dropped. Reset is synchronous and empties the set.
//
module min_partition_difference
   import mpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WEIGHT_BITS-1:0] req_weight,
   input  logic                   req_last_weight,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SUM_BITS-1:0]    rsp_min_difference
);

   cmd_type    cmd;
   status_type status;

   // Controller.
   mpd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_weight (req_last_weight),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .status          (status)
   );

   // Datapath.
   mpd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_weight      (req_weight),
      .cmd             (cmd),
      .status          (status),
      .best_difference (rsp_min_difference)
   );

endmodule
